FILE: src/lpe_pkg.sv
// Shared types, constants and a helper function for the line position estimator.
// Used by every RTL file of the block and by its checker; depends on nothing.
package lpe_pkg;

   localparam int SENSOR_W             = 10;
   localparam int INPUT_FIELDS         = 5;
   localparam int SENSOR_COUNT_DEFAULT = 5;
   localparam int STEP_WEIGHT          = 1000;
   localparam int WEIGHT_W             = 13;
   localparam int IDX_MAX_W            = 3;
   localparam int NUM_W                = 24;
   localparam int DEN_W                = 13;
   localparam int POS_W                = 12;
   localparam int SPAN_W               = 13;
   localparam int CSR_INDEX_W          = 1;
   localparam int CSR_DATA_W           = 10;

   localparam logic [POS_W-1:0]      POS_MAX             = 12'd4095;
   localparam logic [POS_W-1:0]      SEEN_POS_MAX        = 12'd4000;
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET     = 10'd200;
   localparam logic [CSR_DATA_W-1:0] FULL_SCALE_RESET    = 10'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFF_LINE_THRESHOLD = 1'b0,
      CSR_FULL_SCALE         = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Status of the accumulator towards the controller.
   typedef struct packed {
      logic             done;
      logic             seen;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } acc_result_type;

   // Weight of one sensor: its index times the sensor step.
   function automatic logic [WEIGHT_W-1:0] step_weight(input logic [IDX_MAX_W-1:0] idx);
      step_weight = WEIGHT_W'(idx) * WEIGHT_W'(STEP_WEIGHT);
   endfunction

endpackage

FILE: src/lpe_if.sv
// Handshake channels of the line position estimator: request and response.
// Depends on lpe_pkg for the field widths.
interface lpe_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpe_pkg::SENSOR_W-1:0]  sensor_0;
   logic [lpe_pkg::SENSOR_W-1:0]  sensor_1;
   logic [lpe_pkg::SENSOR_W-1:0]  sensor_2;
   logic [lpe_pkg::SENSOR_W-1:0]  sensor_3;
   logic [lpe_pkg::SENSOR_W-1:0]  sensor_4;

   modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                   input ready);
   modport sink   (input valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
                   output ready);
endinterface

interface lpe_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lpe_pkg::POS_W-1:0]  position;
   logic                       line_seen;

   modport source (output valid, position, line_seen, input ready);
   modport sink   (input valid, position, line_seen, output ready);
endinterface

FILE: src/lpe_accum.sv
// Sensor accumulator: shifts the frame out one reading per cycle and builds the
// weighted sum, the plain sum and the seen flag. Depends on lpe_pkg.
module lpe_accum #(
   parameter int SENSOR_COUNT = lpe_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpe_pkg::SENSOR_W-1:0]  sensors [lpe_pkg::INPUT_FIELDS],
   input  logic [lpe_pkg::SENSOR_W-1:0]  threshold,
   output lpe_pkg::acc_result_type       result
);

   localparam int IDX_W  = $clog2(SENSOR_COUNT);
   localparam int PROD_W = lpe_pkg::WEIGHT_W + lpe_pkg::SENSOR_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

   logic [lpe_pkg::SENSOR_W-1:0] load     [SENSOR_COUNT];
   logic [lpe_pkg::SENSOR_W-1:0] value_ff [SENSOR_COUNT];
   logic [lpe_pkg::SENSOR_W-1:0] value_in [SENSOR_COUNT];
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         seen_ff, seen_in;
   logic [lpe_pkg::NUM_W-1:0]    num_ff, num_in;
   logic [lpe_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [PROD_W-1:0]            product;

   // Sensors without an input field read as zero.
   for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_load
      if (i < lpe_pkg::INPUT_FIELDS) begin : g_field
         assign load[i] = sensors[i];
      end else begin : g_zero
         assign load[i] = '0;
      end
   end

   assign product = PROD_W'(lpe_pkg::step_weight(lpe_pkg::IDX_MAX_W'(idx_ff)))
                    * PROD_W'(value_ff[0]);

   always_comb begin
      value_in = value_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      seen_in  = seen_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      if (start) begin
         value_in = load;
         idx_in   = '0;
         busy_in  = 1'b1;
         seen_in  = 1'b0;
         num_in   = '0;
         den_in   = '0;
      end else if (busy_ff) begin
         num_in  = num_ff + lpe_pkg::NUM_W'(product);
         den_in  = den_ff + lpe_pkg::DEN_W'(value_ff[0]);
         seen_in = seen_ff | (value_ff[0] > threshold);
         for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
            value_in[i] = value_ff[i+1];
         end
         value_in[SENSOR_COUNT-1] = '0;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      value_ff <= value_in;
      seen_ff  <= seen_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
   end

   assign result.done = done_ff;
   assign result.seen = seen_ff;
   assign result.num  = num_ff;
   assign result.den  = den_ff;

endmodule

FILE: src/lpe_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, most significant
// first. Depends on lpe_pkg for the operand widths.
module lpe_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lpe_pkg::NUM_W-1:0]   numerator,
   input  logic [lpe_pkg::DEN_W-1:0]   denominator,
   output logic                        done,
   output logic [lpe_pkg::NUM_W-1:0]   quotient
);

   localparam int NUM_W = lpe_pkg::NUM_W;
   localparam int DEN_W = lpe_pkg::DEN_W;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // The remainder stays below the divisor, so it fits in DEN_W bits.
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = numerator;
         den_in   = denominator;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/line_position_estimator_top.sv
// Line position estimator: weighted centroid of a row of line sensors.
// Each request carries one frame of calibrated readings, index 0 leftmost.
// The block returns one response per request: the position, 1000 per sensor
// step with 0 at the left, and a flag telling whether any reading exceeded the
// off-line threshold. When the line is seen, the position is the sum of
// index*1000*reading divided by the sum of readings, truncated, and is kept as
// the last known position. When it is not seen, the position snaps to 0 if the
// last known position lay left of centre, and to (SENSOR_COUNT-1)*full_scale
// otherwise (saturated at 4095). One request at a time is worked on: the
// accumulator shifts the readings through one per cycle, then, for a seen
// frame only, the bit-serial divider works out one quotient bit per cycle.
// A finished response waits in the output register, and the block takes the
// next request while it waits. Registers are written through the csr_ port:
// index 0 is the off-line threshold (reset 200), index 1 the full scale (reset
// 1000); they should only be written while no request is in flight.
// Depends on lpe_pkg, lpe_if, lpe_accum and lpe_divider.
module line_position_estimator_top #(
   parameter int SENSOR_COUNT = lpe_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   lpe_req_if.sink                         req_bus,
   lpe_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_enable,
   input  logic [lpe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpe_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int POS_W  = lpe_pkg::POS_W;
   localparam int SPAN_W = lpe_pkg::SPAN_W;

   lpe_pkg::state_type            state_ff, state_in;
   logic [lpe_pkg::CSR_DATA_W-1:0] threshold_ff;
   logic [lpe_pkg::CSR_DATA_W-1:0] full_scale_ff;
   logic [POS_W-1:0]               last_position_ff, last_position_in;
   logic                           seen_ff, seen_in;
   logic                           den_zero_ff, den_zero_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]               rsp_position_ff, rsp_position_in;
   logic                           rsp_line_seen_ff, rsp_line_seen_in;

   logic [lpe_pkg::SENSOR_W-1:0]   sensors [lpe_pkg::INPUT_FIELDS];
   lpe_pkg::acc_result_type        acc_result;
   logic                           accept;
   logic                           div_start;
   logic                           div_done;
   logic [lpe_pkg::NUM_W-1:0]      quotient;
   logic                           out_free;
   logic                           finish;
   logic [SPAN_W-1:0]              span;
   logic [POS_W-1:0]               off_line_pos;
   logic [POS_W-1:0]               seen_pos;
   logic [POS_W-1:0]               position;

   assign sensors[0] = req_bus.sensor_0;
   assign sensors[1] = req_bus.sensor_1;
   assign sensors[2] = req_bus.sensor_2;
   assign sensors[3] = req_bus.sensor_3;
   assign sensors[4] = req_bus.sensor_4;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= lpe_pkg::THRESHOLD_RESET;
         full_scale_ff <= lpe_pkg::FULL_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (lpe_pkg::csr_index_type'(csr_index))
            lpe_pkg::CSR_OFF_LINE_THRESHOLD: threshold_ff  <= csr_write_data;
            lpe_pkg::CSR_FULL_SCALE:         full_scale_ff <= csr_write_data;
         endcase
      end
   end

   lpe_accum #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .sensors   (sensors),
      .threshold (threshold_ff),
      .result    (acc_result)
   );

   lpe_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (acc_result.num),
      .denominator (acc_result.den),
      .done        (div_done),
      .quotient    (quotient)
   );

   // The output register is free when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpe_pkg::ST_IDLE: begin
            if (req_bus.valid) state_in = lpe_pkg::ST_ACCUM;
         end
         lpe_pkg::ST_ACCUM: begin
            if (acc_result.done) begin
               state_in = acc_result.seen ? lpe_pkg::ST_DIVIDE : lpe_pkg::ST_FINISH;
            end
         end
         lpe_pkg::ST_DIVIDE: begin
            if (div_done) state_in = lpe_pkg::ST_FINISH;
         end
         lpe_pkg::ST_FINISH: begin
            if (out_free) state_in = lpe_pkg::ST_IDLE;
         end
         default: state_in = lpe_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_bus.ready = 1'b0;
      div_start     = 1'b0;
      finish        = 1'b0;
      unique case (state_ff)
         lpe_pkg::ST_IDLE:   req_bus.ready = 1'b1;
         lpe_pkg::ST_ACCUM:  div_start     = acc_result.done && acc_result.seen;
         lpe_pkg::ST_DIVIDE: ;
         lpe_pkg::ST_FINISH: finish        = out_free;
         default: ;
      endcase
   end

   assign accept = req_bus.valid && req_bus.ready;

   // Keep the seen flag and the zero-sum guard once the accumulator is done.
   always_comb begin
      seen_in     = seen_ff;
      den_zero_in = den_zero_ff;
      if (acc_result.done) begin
         seen_in     = acc_result.seen;
         den_zero_in = (acc_result.den == '0);
      end
   end

   // Off-line extreme and centre test against the last known position.
   assign span = SPAN_W'(SENSOR_COUNT - 1) * SPAN_W'(full_scale_ff);
   always_comb begin
      if (SPAN_W'(last_position_ff) < (span >> 1)) begin
         off_line_pos = '0;
      end else if (span > SPAN_W'(lpe_pkg::POS_MAX)) begin
         off_line_pos = lpe_pkg::POS_MAX;
      end else begin
         off_line_pos = span[POS_W-1:0];
      end
   end

   // Seen position: saturated quotient, or zero if the sum of readings was zero.
   always_comb begin
      if (den_zero_ff) begin
         seen_pos = '0;
      end else if (|quotient[lpe_pkg::NUM_W-1:POS_W]) begin
         seen_pos = lpe_pkg::POS_MAX;
      end else begin
         seen_pos = quotient[POS_W-1:0];
      end
   end

   assign position = seen_ff ? seen_pos : off_line_pos;

   always_comb begin
      last_position_in = last_position_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_position_in  = rsp_position_ff;
      rsp_line_seen_in = rsp_line_seen_ff;
      if (finish) begin
         rsp_valid_in     = 1'b1;
         rsp_position_in  = position;
         rsp_line_seen_in = seen_ff;
         if (seen_ff) last_position_in = seen_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lpe_pkg::ST_IDLE;
         last_position_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         last_position_ff <= last_position_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      seen_ff          <= seen_in;
      den_zero_ff      <= den_zero_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_line_seen_ff <= rsp_line_seen_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.position  = rsp_position_ff;
   assign rsp_bus.line_seen = rsp_line_seen_ff;

endmodule

FILE: src/lpe_checker.sv
// Port-level checker for the line position estimator, bound to the top level.
// Depends on lpe_pkg and line_position_estimator_top.
module lpe_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lpe_pkg::POS_W-1:0]   rsp_position,
   input logic                        rsp_line_seen
);

   // A waiting response holds its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                  && $stable(rsp_line_seen))
      else $error("response changed while stalled");

   // The block works on one request at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // No response can appear in the cycle right after a request is taken.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared too soon");

   // A centroid never lies beyond the rightmost sensor with an input.
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_seen |-> rsp_position <= lpe_pkg::SEEN_POS_MAX)
      else $error("seen position out of range");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind line_position_estimator_top lpe_checker u_lpe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_position  (rsp_bus.position),
   .rsp_line_seen (rsp_bus.line_seen)
);
